>>> rtl/lcd_nibble_write_sequencer_assert.svh
// Assertion macros shared by the LCD nibble write sequencer RTL.
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LNWS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lnws: same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define LNWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lnws: next-cycle check failed");

`endif

>>> rtl/lnws_pkg.sv
// Types, codes and microcode ROM of the LCD nibble write sequencer.
`default_nettype none
package lnws_pkg;

	// request kinds
	localparam logic [1:0] FUNC_INIT = 2'd0;
	localparam logic [1:0] FUNC_CMD  = 2'd1;
	localparam logic [1:0] FUNC_DATA = 2'd2;
	localparam logic [1:0] FUNC_NUM  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_PULSE  = 2'd0;
	localparam logic [1:0] REG_SETTLE = 2'd1;
	localparam logic [1:0] REG_CLEAR  = 2'd2;

	localparam logic [15:0] PULSE_RST  = 16'd2;
	localparam logic [15:0] SETTLE_RST = 16'd100;
	localparam logic [15:0] CLEAR_RST  = 16'd2000;

	// microcode word kinds
	localparam logic [1:0] K_STEP = 2'd0; // one step, low nibble, E low
	localparam logic [1:0] K_BYTE = 2'd1; // four steps, one per phase
	localparam logic [1:0] K_WAIT = 2'd2; // hold pc until digits are ready

	// byte sources
	localparam logic [2:0] SRC_CONST = 3'd0;
	localparam logic [2:0] SRC_IN    = 3'd1;
	localparam logic [2:0] SRC_D0    = 3'd2;
	localparam logic [2:0] SRC_D1    = 3'd3;
	localparam logic [2:0] SRC_D2    = 3'd4;

	// RS selection
	localparam logic [1:0] RS_CMD  = 2'd0;
	localparam logic [1:0] RS_DATA = 2'd1;
	localparam logic [1:0] RS_FUNC = 2'd2;

	// hold selection for single steps
	localparam logic [1:0] HOLD_ZERO   = 2'd0;
	localparam logic [1:0] HOLD_PULSE  = 2'd1;
	localparam logic [1:0] HOLD_SETTLE = 2'd2;
	localparam logic [1:0] HOLD_CLEAR  = 2'd3;

	localparam int PC_W = 4;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] src;
		logic [7:0] cbyte;
		logic [1:0] rs;
		logic [1:0] hold;
		logic       fin;
	} uop_t;

	// digit unit status toward the sequencer
	typedef struct packed {
		logic       ready;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
	} dig_t;

	function automatic uop_t mk(input logic [1:0] kind, input logic [2:0] src,
		input logic [7:0] cbyte, input logic [1:0] rs, input logic [1:0] hold,
		input logic fin);
		uop_t u;
		u.kind  = kind;
		u.src   = src;
		u.cbyte = cbyte;
		u.rs    = rs;
		u.hold  = hold;
		u.fin   = fin;
		return u;
	endfunction

	function automatic uop_t ucode_rom(input pc_t pc);
		uop_t u;
		case (pc)
			// init
			4'd0:    u = mk(K_STEP, SRC_CONST, 8'h00, RS_CMD, HOLD_ZERO, 1'b0);
			4'd1:    u = mk(K_BYTE, SRC_CONST, 8'h33, RS_CMD, HOLD_ZERO, 1'b0);
			4'd2:    u = mk(K_BYTE, SRC_CONST, 8'h32, RS_CMD, HOLD_ZERO, 1'b0);
			4'd3:    u = mk(K_BYTE, SRC_CONST, 8'h28, RS_CMD, HOLD_ZERO, 1'b0);
			4'd4:    u = mk(K_BYTE, SRC_CONST, 8'h0e, RS_CMD, HOLD_ZERO, 1'b0);
			4'd5:    u = mk(K_BYTE, SRC_CONST, 8'h01, RS_CMD, HOLD_ZERO, 1'b0);
			4'd6:    u = mk(K_STEP, SRC_CONST, 8'h01, RS_CMD, HOLD_CLEAR, 1'b0);
			4'd7:    u = mk(K_BYTE, SRC_CONST, 8'h06, RS_CMD, HOLD_ZERO, 1'b1);
			// command or data byte
			4'd8:    u = mk(K_BYTE, SRC_IN, 8'h00, RS_FUNC, HOLD_ZERO, 1'b1);
			// print number
			4'd9:    u = mk(K_WAIT, SRC_CONST, 8'h00, RS_DATA, HOLD_ZERO, 1'b0);
			4'd10:   u = mk(K_BYTE, SRC_D0, 8'h00, RS_DATA, HOLD_ZERO, 1'b0);
			4'd11:   u = mk(K_BYTE, SRC_D1, 8'h00, RS_DATA, HOLD_ZERO, 1'b0);
			4'd12:   u = mk(K_BYTE, SRC_D2, 8'h00, RS_DATA, HOLD_ZERO, 1'b0);
			4'd13:   u = mk(K_STEP, SRC_D2, 8'h00, RS_DATA, HOLD_SETTLE, 1'b0);
			4'd14:   u = mk(K_BYTE, SRC_CONST, 8'h02, RS_CMD, HOLD_ZERO, 1'b1);
			default: u = mk(K_STEP, SRC_CONST, 8'h00, RS_CMD, HOLD_ZERO, 1'b1);
		endcase
		return u;
	endfunction

	function automatic pc_t entry_pc(input logic [1:0] func);
		pc_t pc;
		case (func)
			FUNC_INIT: pc = 4'd0;
			FUNC_CMD:  pc = 4'd8;
			FUNC_DATA: pc = 4'd8;
			FUNC_NUM:  pc = 4'd9;
			default:   pc = 4'd0;
		endcase
		return pc;
	endfunction

endpackage
`default_nettype wire

>>> rtl/lnws_digits.sv
// Three-digit ASCII conversion pipeline for number printing.
`default_nettype none
module lnws_digits (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [15:0]    number,
	output lnws_pkg::dig_t      dig
);
	logic [15:0] num_q;
	logic [9:0]  q_s1;
	logic [7:0]  d0_s2;
	logic [6:0]  r_s2;
	logic [3:0]  t_s3;
	logic [3:0]  ones_s4;
	logic [2:0]  cnt_q;

	logic [28:0] qprod;
	logic [16:0] qx100;
	logic [16:0] rem_full;
	logic [7:0]  rem8;
	logic        fix;
	logic [9:0]  q_fix;
	logic [7:0]  r_fix;
	logic [14:0] tprod;
	logic [7:0]  tx10;

	// reciprocal of 100 rounded down: quotient is exact or one short
	assign qprod    = 29'(num_q) * 29'd5242;
	assign qx100    = 17'(q_s1) * 17'd100;
	assign rem_full = {1'b0, num_q} - qx100;
	assign rem8     = rem_full[7:0];
	assign fix      = rem8 >= 8'd100;
	assign q_fix    = fix ? q_s1 + 10'd1 : q_s1;
	assign r_fix    = fix ? rem8 - 8'd100 : rem8;
	// exact division by 10 for values below 100
	assign tprod    = 15'(r_s2) * 15'd205;
	assign tx10     = 8'(t_s3) * 8'd10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (start) begin
			cnt_q <= 3'd0;
		end else if (cnt_q != 3'd4) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= number;
		end
		q_s1    <= qprod[28:19];
		d0_s2   <= 8'(q_fix) + 8'h30;
		r_s2    <= r_fix[6:0];
		t_s3    <= tprod[14:11];
		ones_s4 <= 4'({1'b0, r_s2} - tx10);
	end

	assign dig.ready = cnt_q == 3'd4;
	assign dig.d0    = d0_s2;
	assign dig.d1    = {4'h3, t_s3};
	assign dig.d2    = {4'h3, ones_s4};

endmodule
`default_nettype wire

>>> rtl/lcd_nibble_write_sequencer.sv
// Top level: microcoded sequencer expanding requests into 4-bit LCD bus steps.
`default_nettype none
// Takes one request (init, command byte, data byte, print number) and emits its
// pin steps one per clock while out_stall is low: 26 steps for init, 4 for a
// byte, 17 for a number. A request is first registered into busy_q and pc_q
// before its first step can load; number printing also holds at the wait word
// while the four digit pipeline stages fill, and loads its first step only after
// it leaves the wait word. The step rate is set by the single output register:
// one step per clock while out_stall is low. A new request is taken on the clock
// after the last step of the previous one is loaded; with no stalls, init is the
// longest request. Hold register writes take effect on the next step loaded.
`include "lcd_nibble_write_sequencer_assert.svh"
module lcd_nibble_write_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  byte_value,
	input  wire logic [15:0] number,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       data_nibble,
	output logic             reg_select,
	output logic             enable,
	output logic [15:0]      hold_us,
	output logic             last,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	logic [15:0]     pulse_q;
	logic [15:0]     settle_q;
	logic [15:0]     clear_q;
	logic            busy_q;
	lnws_pkg::pc_t   pc_q;
	logic [1:0]      phase_q;
	logic [1:0]      func_q;
	logic [7:0]      byte_q;
	logic            out_valid_q;
	logic [3:0]      nib_q;
	logic            rs_q;
	logic            e_q;
	logic [15:0]     hold_q;
	logic            last_q;

	lnws_pkg::uop_t  uop;
	lnws_pkg::dig_t  dig;
	logic            accept;
	logic            out_free;
	logic            is_byte;
	logic            is_wait;
	logic            emit;
	logic [7:0]      sel_byte;
	logic [3:0]      nib_w;
	logic            rs_w;
	logic            e_w;
	logic [15:0]     hold_w;
	logic            last_w;
	logic [15:0]     step_hold;

	assign accept   = in_valid && !busy_q;
	assign uop      = lnws_pkg::ucode_rom(pc_q);
	assign out_free = !out_valid_q || !out_stall;
	assign is_byte  = uop.kind == lnws_pkg::K_BYTE;
	assign is_wait  = uop.kind == lnws_pkg::K_WAIT;
	assign emit     = busy_q && !is_wait && out_free;

	lnws_digits u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.number (number),
		.dig    (dig)
	);

	always_comb begin
		case (uop.src)
			lnws_pkg::SRC_CONST: sel_byte = uop.cbyte;
			lnws_pkg::SRC_IN:    sel_byte = byte_q;
			lnws_pkg::SRC_D0:    sel_byte = dig.d0;
			lnws_pkg::SRC_D1:    sel_byte = dig.d1;
			lnws_pkg::SRC_D2:    sel_byte = dig.d2;
			default:             sel_byte = uop.cbyte;
		endcase
		case (uop.rs)
			lnws_pkg::RS_CMD:  rs_w = 1'b0;
			lnws_pkg::RS_DATA: rs_w = 1'b1;
			lnws_pkg::RS_FUNC: rs_w = func_q == lnws_pkg::FUNC_DATA;
			default:           rs_w = 1'b0;
		endcase
		case (uop.hold)
			lnws_pkg::HOLD_ZERO:   step_hold = 16'd0;
			lnws_pkg::HOLD_PULSE:  step_hold = pulse_q;
			lnws_pkg::HOLD_SETTLE: step_hold = settle_q;
			lnws_pkg::HOLD_CLEAR:  step_hold = clear_q;
			default:               step_hold = 16'd0;
		endcase
		if (is_byte) begin
			nib_w  = phase_q[1] ? sel_byte[3:0] : sel_byte[7:4];
			e_w    = !phase_q[0];
			hold_w = phase_q[0] ? settle_q : pulse_q;
			last_w = uop.fin && (phase_q == 2'd3);
		end else begin
			nib_w  = sel_byte[3:0];
			e_w    = 1'b0;
			hold_w = step_hold;
			last_w = uop.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q  <= lnws_pkg::PULSE_RST;
			settle_q <= lnws_pkg::SETTLE_RST;
			clear_q  <= lnws_pkg::CLEAR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lnws_pkg::REG_PULSE:  pulse_q  <= cfg_data;
				lnws_pkg::REG_SETTLE: settle_q <= cfg_data;
				lnws_pkg::REG_CLEAR:  clear_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			phase_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q  <= 1'b1;
				pc_q    <= lnws_pkg::entry_pc(func);
				phase_q <= 2'd0;
			end else if (busy_q) begin
				if (is_wait) begin
					if (dig.ready) begin
						pc_q <= pc_q + lnws_pkg::pc_t'(1);
					end
				end else if (emit) begin
					if (is_byte && phase_q != 2'd3) begin
						phase_q <= phase_q + 2'd1;
					end else begin
						phase_q <= 2'd0;
						if (uop.fin) begin
							busy_q <= 1'b0;
						end else begin
							pc_q <= pc_q + lnws_pkg::pc_t'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			byte_q <= byte_value;
		end
		if (emit) begin
			nib_q  <= nib_w;
			rs_q   <= rs_w;
			e_q    <= e_w;
			hold_q <= hold_w;
			last_q <= last_w;
		end
	end

	assign in_stall    = busy_q;
	assign out_valid   = out_valid_q;
	assign data_nibble = nib_q;
	assign reg_select  = rs_q;
	assign enable      = e_q;
	assign hold_us     = hold_q;
	assign last        = last_q;

	`LNWS_ASSERT_NEXT(a_accept_busy, accept, busy_q)
	`LNWS_ASSERT_NEXT(a_wait_holds, busy_q && is_wait && !dig.ready, busy_q && $stable(pc_q))
	`LNWS_ASSERT_SAME(a_phase_byte, busy_q && phase_q != 2'd0, is_byte)
	`LNWS_ASSERT_NEXT(a_last_ends, emit && last_w, !busy_q && out_valid && last)

endmodule
`default_nettype wire
